// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the 2x2 downscaler.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define DSB_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("downscaler assertion failed");

// Expression that must never be true outside reset.
`define DSB_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("downscaler illegal condition");

`endif

// ===== rtl/dsb_pkg.sv =====
// ----------------------------------------------------------------------------
// dsb_pkg
// Shared types and constants of the 2x2 box-average downscaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dsb_pkg;

    localparam int PIX_W     = 8;
    localparam int SUM_W     = 9;
    localparam int TOT_W     = 10;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int ROW_W     = 12;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [CFG_W-1:0] HEIGHT_LIMIT = 13'd4096;
    localparam logic [CFG_W-1:0] DIM_MIN      = 13'd2;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

    // Per-pixel request from the counter logic to the line buffer / datapath
    typedef struct packed {
        logic wr_en;
        logic emit;
        logic row_end;
        logic frame_end;
    } t_line_req;

endpackage

// ===== rtl/dsb_line_ram.sv =====
// ----------------------------------------------------------------------------
// dsb_line_ram
// Pair-sum line buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsb_line_ram #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [dsb_pkg::SUM_W-1:0] i_wdata,
    input  logic                      i_re,
    input  logic [AW-1:0]             i_raddr,
    output logic [dsb_pkg::SUM_W-1:0] o_rdata
);

    logic [dsb_pkg::SUM_W-1:0] r_mem [DEPTH];
    logic [dsb_pkg::SUM_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dsb_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsb_ctrl
// Configuration registers, raster counters and held pixel; decides per pixel
// whether the line buffer is written or read and which flags go out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dsb_ctrl #(
    parameter int MAX_WIDTH = 4096,
    parameter int CW        = 12,
    parameter int AW        = 11
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dsb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dsb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_accept,
    input  logic [dsb_pkg::PIX_W-1:0]     i_pixel,
    output dsb_pkg::t_line_req            o_req,
    output logic [AW-1:0]                 o_idx,
    output logic [dsb_pkg::SUM_W-1:0]     o_pair_sum
);

    localparam int WW   = CW + 1;
    localparam int CMPW = (WW > dsb_pkg::CFG_W) ? WW : dsb_pkg::CFG_W;
    localparam logic [CMPW-1:0] WMAX = CMPW'(MAX_WIDTH);
    localparam logic [CMPW-1:0] WMIN = CMPW'(2);

    logic [dsb_pkg::CFG_W-1:0] r_width, n_width;
    logic [dsb_pkg::CFG_W-1:0] r_height, n_height;
    logic [CW-1:0]             r_col, n_col;
    logic [dsb_pkg::ROW_W-1:0] r_row, n_row;
    logic [dsb_pkg::PIX_W-1:0] r_held, n_held;

    logic [CMPW-1:0]           w_cmp, w_clamp;
    logic [WW-1:0]             w_eff, pair_w, col_ext, col_inc;
    logic [dsb_pkg::CFG_W-1:0] h_eff, pair_h, row_ext, row_inc;
    logic                      in_pair, last_col;

    always_comb begin
        w_cmp = CMPW'(r_width);
        if (w_cmp < WMIN) begin
            w_clamp = WMIN;
        end else if (w_cmp > WMAX) begin
            w_clamp = WMAX;
        end else begin
            w_clamp = w_cmp;
        end
        w_eff   = w_clamp[WW-1:0];
        pair_w  = {w_eff[WW-1:1], 1'b0};
        col_ext = {1'b0, r_col};
        col_inc = col_ext + WW'(1);

        if (r_height < dsb_pkg::DIM_MIN) begin
            h_eff = dsb_pkg::DIM_MIN;
        end else if (r_height > dsb_pkg::HEIGHT_LIMIT) begin
            h_eff = dsb_pkg::HEIGHT_LIMIT;
        end else begin
            h_eff = r_height;
        end
        pair_h  = {h_eff[dsb_pkg::CFG_W-1:1], 1'b0};
        row_ext = {1'b0, r_row};
        row_inc = row_ext + dsb_pkg::CFG_W'(1);

        in_pair  = r_col[0] && (col_ext < pair_w);
        last_col = (col_ext == pair_w - WW'(1));
    end

    always_comb begin
        o_req.wr_en     = in_pair && !r_row[0];
        o_req.emit      = in_pair && r_row[0] && (row_ext < pair_h);
        o_req.row_end   = last_col;
        o_req.frame_end = last_col && (row_ext == pair_h - dsb_pkg::CFG_W'(1));
        o_idx           = r_col[AW:1];
        o_pair_sum      = {1'b0, r_held} + {1'b0, i_pixel};
    end

    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            case (i_cfg_index)
                dsb_pkg::REG_WIDTH:  n_width  = i_cfg_data;
                dsb_pkg::REG_HEIGHT: n_height = i_cfg_data;
                default: ;
            endcase
        end

        n_col  = r_col;
        n_row  = r_row;
        n_held = r_held;
        if (i_accept) begin
            if (!r_col[0]) begin
                n_held = i_pixel;
            end
            if (col_inc >= w_eff) begin
                n_col = '0;
                n_row = (row_inc >= h_eff) ? '0 : row_inc[dsb_pkg::ROW_W-1:0];
            end else begin
                n_col = col_inc[CW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= dsb_pkg::WIDTH_RESET;
            r_height <= dsb_pkg::HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_held   <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_col    <= n_col;
            r_row    <= n_row;
            r_held   <= n_held;
        end
    end

endmodule

// ===== rtl/downscale_2x2_box_average.sv =====
// ----------------------------------------------------------------------------
// downscale_2x2_box_average
// 2x2 box-filter downsampler for 8-bit greyscale raster streams.
// ----------------------------------------------------------------------------
// Takes one pixel per clock, sustained, with no gaps at row or frame borders;
// the input stalls only while both the read stage and the output register hold
// results that the receiver has not yet taken.
// Top-row pixel pairs are summed into a line buffer of MAX_WIDTH/2 x 9 bits
// (one write port and one read port, never both used at once, no clearing
// pass after reset); on the bottom row each odd column reads that sum back,
// the read stage registers it and the output register then takes the total.
// Width and height may only be changed while the block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module downscale_2x2_box_average #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dsb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dsb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dsb_pkg::PIX_W-1:0]     i_pixel_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dsb_pkg::PIX_W-1:0]     o_average_pixel,
    output logic                          o_row_end,
    output logic                          o_frame_end
);

    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = $clog2(LINE_DEPTH);

    dsb_pkg::t_line_req        req;
    logic [AW-1:0]             idx;
    logic [dsb_pkg::SUM_W-1:0] pair_sum, line_rdata;
    logic                      accept, load_out;
    logic [dsb_pkg::TOT_W-1:0] total;

    logic                      r_s1_valid, n_s1_valid;
    logic [dsb_pkg::SUM_W-1:0] r_s1_sum;
    logic                      r_s1_row_end, r_s1_frame_end;
    logic                      r_out_valid, n_out_valid;
    logic [dsb_pkg::PIX_W-1:0] r_avg;
    logic                      r_row_end, r_frame_end;

    assign o_cfg_ready = 1'b1;
    assign load_out    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_s1_valid || load_out;
    assign accept      = i_in_valid && o_in_ready;

    dsb_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW),
        .AW        (AW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_pixel     (i_pixel_in),
        .o_req       (req),
        .o_idx       (idx),
        .o_pair_sum  (pair_sum)
    );

    dsb_line_ram #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (accept && req.wr_en),
        .i_waddr (idx),
        .i_wdata (pair_sum),
        .i_re    (accept && req.emit),
        .i_raddr (idx),
        .o_rdata (line_rdata)
    );

    assign total = {1'b0, line_rdata} + {1'b0, r_s1_sum};

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (load_out) begin
            n_s1_valid = 1'b0;
        end
        if (accept && req.emit) begin
            n_s1_valid = 1'b1;
        end

        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && req.emit) begin
            r_s1_sum       <= pair_sum;
            r_s1_row_end   <= req.row_end;
            r_s1_frame_end <= req.frame_end;
        end
        if (load_out) begin
            r_avg       <= total[dsb_pkg::TOT_W-1:2];
            r_row_end   <= r_s1_row_end;
            r_frame_end <= r_s1_frame_end;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_average_pixel = r_avg;
    assign o_row_end       = r_row_end;
    assign o_frame_end     = r_frame_end;

    `DSB_NEVER(a_wr_rd_exclusive, req.wr_en && req.emit)
    `DSB_ASSERT(a_emit_fills_s1, (accept && req.emit) |=> r_s1_valid)
    `DSB_ASSERT(a_s1_held, (r_s1_valid && !load_out) |=> (r_s1_valid && $stable(r_s1_sum)))
    `DSB_ASSERT(a_frame_end_row_end, (o_out_valid && o_frame_end) |-> o_row_end)

endmodule

// ===== tb/downscale_2x2_box_average_tb.sv =====
// ----------------------------------------------------------------------------
// downscale_2x2_box_average_tb
// Self-checking bench for the 2x2 box-average downscaler.
// ----------------------------------------------------------------------------
// Streams greyscale pixels through the valid/ready input, predicts each 2x2
// average with its row-end and frame-end flags in a scoreboard, and compares
// every output transaction against the oldest prediction. Covers directed
// corner values, odd and clamped image sizes, size changes on an even row
// between phases, a long output back-pressure stretch, and random throttling
// on both sides.
`timescale 1ns / 1ps

module downscale_2x2_box_average_tb;

    localparam int MAX_W        = 4096;
    localparam int LINE_DEPTH   = MAX_W / 2;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int QUIET_LIMIT  = 5000;
    localparam int RANDOM_ITEMS = 750;
    localparam int PHASE_CAP    = 120;

    typedef struct packed {
        logic [dsb_pkg::PIX_W-1:0] average;
        logic                      row_end;
        logic                      frame_end;
    } t_avg_result;

    class box_avg_scoreboard;
        logic [dsb_pkg::CFG_W-1:0] width_reg;
        logic [dsb_pkg::CFG_W-1:0] height_reg;
        int unsigned               col_count;
        int unsigned               row_count;
        logic [dsb_pkg::PIX_W-1:0] held;
        logic [dsb_pkg::SUM_W-1:0] pair_sums [LINE_DEPTH];
        t_avg_result               expected_averages [$];
        int                        failures;
        int                        pixels_seen;
        int                        averages_checked;

        function new();
            width_reg        = dsb_pkg::WIDTH_RESET;
            height_reg       = dsb_pkg::HEIGHT_RESET;
            col_count        = 0;
            row_count        = 0;
            held             = '0;
            failures         = 0;
            pixels_seen      = 0;
            averages_checked = 0;
        endfunction

        function void set_register(input logic [dsb_pkg::CFG_IDX_W-1:0] idx,
                                   input logic [dsb_pkg::CFG_W-1:0] data);
            case (idx)
                dsb_pkg::REG_WIDTH:  width_reg = data;
                dsb_pkg::REG_HEIGHT: height_reg = data;
                default: ;
            endcase
        endfunction

        function int unsigned eff_width();
            if (width_reg < dsb_pkg::DIM_MIN) return 32'(dsb_pkg::DIM_MIN);
            if (width_reg > MAX_W) return MAX_W;
            return 32'(width_reg);
        endfunction

        function int unsigned eff_height();
            if (height_reg < dsb_pkg::DIM_MIN) return 32'(dsb_pkg::DIM_MIN);
            if (height_reg > dsb_pkg::HEIGHT_LIMIT) return 32'(dsb_pkg::HEIGHT_LIMIT);
            return 32'(height_reg);
        endfunction

        function int unsigned pixels_to_frame_end();
            int unsigned w;
            int unsigned h;
            w = eff_width();
            h = eff_height();
            if (col_count >= w) begin
                return (row_count + 1 >= h) ? 1 : 1 + (h - row_count - 1) * w;
            end
            if (row_count >= h) return w - col_count;
            return (h - row_count) * w - col_count;
        endfunction

        function void note_pixel(input logic [dsb_pkg::PIX_W-1:0] p);
            int unsigned               w;
            int unsigned               h;
            int unsigned               pair_w;
            int unsigned               pair_h;
            int unsigned               slot;
            logic [dsb_pkg::TOT_W-1:0] total;
            logic                      last_col;
            t_avg_result               item;
            w      = eff_width();
            h      = eff_height();
            pair_w = w - (w % 2);
            pair_h = h - (h % 2);
            slot   = col_count >> 1;
            pixels_seen++;
            if (col_count % 2 == 0) begin
                held = p;
            end else if (col_count < pair_w) begin
                if (row_count % 2 == 0) begin
                    pair_sums[slot] = {1'b0, held} + {1'b0, p};
                end else if (row_count < pair_h) begin
                    total = {1'b0, pair_sums[slot]} + {2'b00, held} + {2'b00, p};
                    last_col       = (col_count == pair_w - 1);
                    item.average   = total[dsb_pkg::TOT_W-1:2];
                    item.row_end   = last_col;
                    item.frame_end = last_col && (row_count == pair_h - 1);
                    expected_averages = {expected_averages, item};
                end
            end
            if (col_count + 1 >= w) begin
                col_count = 0;
                row_count = (row_count + 1 >= h) ? 0 : row_count + 1;
            end else begin
                col_count++;
            end
        endfunction

        function void check_result(input logic [dsb_pkg::PIX_W-1:0] average,
                                   input logic row_end, input logic frame_end);
            t_avg_result exp_res;
            if (expected_averages.size() == 0) begin
                failures++;
                $display("%0t: unexpected output, expected none, got %0d/%0b/%0b",
                         $time, average, row_end, frame_end);
                return;
            end
            exp_res = expected_averages.pop_front();
            averages_checked++;
            if (average !== exp_res.average) begin
                failures++;
                $display("%0t: average_pixel mismatch, expected %0d, got %0d",
                         $time, exp_res.average, average);
            end
            if (row_end !== exp_res.row_end) begin
                failures++;
                $display("%0t: row_end mismatch, expected %0b, got %0b",
                         $time, exp_res.row_end, row_end);
            end
            if (frame_end !== exp_res.frame_end) begin
                failures++;
                $display("%0t: frame_end mismatch, expected %0b, got %0b",
                         $time, exp_res.frame_end, frame_end);
            end
        endfunction
    endclass

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [dsb_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [dsb_pkg::CFG_W-1:0]     i_cfg_data  = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    logic [dsb_pkg::PIX_W-1:0]     i_pixel_in  = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic [dsb_pkg::PIX_W-1:0]     o_average_pixel;
    logic                          o_row_end;
    logic                          o_frame_end;

    box_avg_scoreboard sb = new();

    int send_idle    = 0;
    int recv_idle    = 0;
    int random_items = 0;
    int cfg_writes   = 0;
    int quiet_cycles = 0;
    int hold_left    = 0;
    bit hold_toggle  = 1'b0;
    bit hold_seen    = 1'b0;

    downscale_2x2_box_average #(
        .MAX_WIDTH(MAX_W)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pixel_in      (i_pixel_in),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_average_pixel (o_average_pixel),
        .o_row_end       (o_row_end),
        .o_frame_end     (o_frame_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Output side: check, then decide ready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_average_pixel, o_row_end, o_frame_end);
        end
        if (hold_seen != hold_toggle) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [dsb_pkg::PIX_W-1:0] random_pixel();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [dsb_pkg::CFG_W-1:0] pick_width();
        case ($urandom_range(9))
            0:       return 13'($urandom_range(1));
            1: begin
                case ($urandom_range(2))
                    0:       return 13'd4096;
                    1:       return 13'h1FFF;
                    default: return 13'($urandom_range(4097, 8190));
                endcase
            end
            2:       return 13'(2 * $urandom_range(1, 16) + 1);
            3:       return 13'($urandom_range(2, 40));
            default: return 13'(8 * $urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [dsb_pkg::CFG_W-1:0] pick_height();
        case ($urandom_range(9))
            0:       return 13'($urandom_range(1));
            1: begin
                case ($urandom_range(2))
                    0:       return 13'd4096;
                    1:       return 13'h1FFF;
                    default: return 13'($urandom_range(4097, 8190));
                endcase
            end
            2:       return 13'(2 * $urandom_range(1, 4) + 1);
            default: return 13'($urandom_range(2, 8));
        endcase
    endfunction

    task automatic send_pixel(input logic [dsb_pkg::PIX_W-1:0] p);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_in <= p;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_pixel(p);
    endtask

    task automatic send_random(input int unsigned n);
        repeat (n) send_pixel(random_pixel());
    endtask

    task automatic cfg_transfer(input logic [dsb_pkg::CFG_IDX_W-1:0] idx,
                                input logic [dsb_pkg::CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, data);
        cfg_writes++;
    endtask

    task automatic configure(input bit set_w, input logic [dsb_pkg::CFG_W-1:0] w,
                             input bit set_h, input logic [dsb_pkg::CFG_W-1:0] h);
        if (set_w) cfg_transfer(dsb_pkg::REG_WIDTH, w);
        if (set_h) cfg_transfer(dsb_pkg::REG_HEIGHT, h);
        i_cfg_valid <= 1'b0;
    endtask

    // Wait for every predicted average, then let the pipeline empty
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.expected_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Size changes only on an even row, so a bottom row never reads an
    // unwritten line-buffer entry
    task automatic run_phase();
        bit          set_w;
        bit          set_h;
        int unsigned n;
        settle();
        if (sb.row_count % 2 == 0) begin
            set_w = (sb.eff_width() > 64) || ($urandom_range(2) == 0);
            set_h = (sb.eff_height() > 64) || ($urandom_range(2) == 0);
            configure(set_w, pick_width(), set_h, pick_height());
        end
        n = sb.pixels_to_frame_end();
        if (n > PHASE_CAP || $urandom_range(4) == 0) n = $urandom_range(1, 48);
        send_random(n);
        random_items += n;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle = 26;
        recv_idle = 86;

        // 8x2: zeros, full scale, floor rounding, row and frame end
        configure(1'b1, 13'd8, 1'b1, 13'd2);
        send_pixel(8'd0);   send_pixel(8'd0);   send_pixel(8'd255); send_pixel(8'd255);
        send_pixel(8'd255); send_pixel(8'd254); send_pixel(8'd1);   send_pixel(8'd1);
        send_pixel(8'd0);   send_pixel(8'd0);   send_pixel(8'd255); send_pixel(8'd255);
        send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd1);   send_pixel(8'd0);
        settle();
        // 3x3: odd width and odd height, trailing column and row dropped
        configure(1'b1, 13'd3, 1'b1, 13'd3);
        send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd7);
        send_pixel(8'd255); send_pixel(8'd255); send_pixel(8'd9);
        send_pixel(8'd1);   send_pixel(8'd2);   send_pixel(8'd3);

        while (random_items < RANDOM_ITEMS / 3) run_phase();

        send_idle = 86;
        recv_idle = 26;
        while (random_items < 2 * RANDOM_ITEMS / 3) run_phase();

        send_idle = 0;
        recv_idle = 0;
        // Long output stall while input keeps coming, set up from an even row
        settle();
        while (sb.row_count % 2 != 0) send_pixel(random_pixel());
        settle();
        configure(1'b1, 13'd16, 1'b1, 13'd4);
        send_random(sb.pixels_to_frame_end());
        settle();
        hold_toggle <= ~hold_toggle;
        send_random(sb.pixels_to_frame_end());

        while (random_items < RANDOM_ITEMS) run_phase();

        settle();
        repeat (16) @(posedge i_clk);
        $display("Checked %0d averages from %0d pixels across %0d register writes,",
                 sb.averages_checked, sb.pixels_seen, cfg_writes);
        $display("with odd and clamped sizes, size changes and output back-pressure.");
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== downscale_2x2_box_average.f =====
+incdir+rtl
rtl/dsb_pkg.sv
rtl/dsb_line_ram.sv
rtl/dsb_ctrl.sv
rtl/downscale_2x2_box_average.sv
tb/downscale_2x2_box_average_tb.sv
